// ===== sv/twf_pkg.sv =====
// Shared widths, payload types and register codes for the triangle wind force block.
`timescale 1ns / 1ps

package twf_pkg;

    // Input component format: two's complement, 12 fraction bits.
    localparam int COMPONENT_BITS = 20;
    localparam int IN_W           = 3 * COMPONENT_BITS;

    // Configuration port.
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIND_X    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WIND_Y    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WIND_Z    = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] TIME_STEP_RESET = CFG_W'(41);

    // Datapath widths.
    localparam int E_W     = COMPONENT_BITS + 1;
    localparam int N_W     = 2 * COMPONENT_BITS + 3;
    localparam int NM_W    = N_W - 1;
    localparam int VS_BASE = (COMPONENT_BITS > CFG_W) ? COMPONENT_BITS : CFG_W;
    localparam int VS_W    = VS_BASE + 4;
    localparam int VM_W    = VS_W - 1;
    localparam int NN_W    = 2 * NM_W + 2;
    localparam int D_W     = NM_W + VM_W + 2;
    localparam int GAIN_W  = 8;
    localparam int G_W     = CFG_W + GAIN_W;
    localparam int DSQ_W   = 2 * D_W;
    localparam int M_W     = G_W + NM_W;
    localparam int PROD_W  = DSQ_W + M_W;
    localparam int DEN_W   = NN_W + 4;
    localparam int Q_W     = 32;

    // Collected drag constant 1000 * 0.5 * 0.33 = 165, and the fixed-point scale shift.
    localparam int DRAG_GAIN = 165;
    localparam int DEN_SHIFT = 52;
    localparam int NUM_W     = PROD_W - DEN_SHIFT;
    localparam int REM_W     = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    // Pipelined arithmetic units.
    localparam int LIMB_W  = 24;
    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = Q_W + 1;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [IN_W-1:0] pos_a;
        logic [IN_W-1:0] pos_b;
        logic [IN_W-1:0] pos_c;
        logic [IN_W-1:0] vel_a;
        logic [IN_W-1:0] vel_b;
        logic [IN_W-1:0] vel_c;
    } twf_in_t;

    typedef struct packed {
        logic signed [31:0] delta_vx;
        logic signed [31:0] delta_vy;
        logic signed [31:0] delta_vz;
        logic               degenerate;
        logic               saturated;
    } twf_out_t;

    // Classified triangle handed from the front end to the back end.
    typedef struct packed {
        logic [2:0][N_W-1:0]  n;
        logic [2:0][VS_W-1:0] vs;
        logic                 deg;
    } twf_mid_t;

endpackage

// ===== sv/triangle_wind_force_top.sv =====
// Top level of the triangle wind force block: configuration registers, front end, queue, back end.
//
//   Channel   Direction   Handshake              Payload
//   in        input       in_valid / in_ready    in_item   (twf_in_t)
//   out       output      out_valid / out_ready  out_item  (twf_out_t)
//   cfg       input       cfg_we                 cfg_index, cfg_data
//
// One triangle is accepted every cycle while the output side takes results.
// Most of the path from a triangle's transfer to the output is the 33-stage quotient
// pipeline in the back end: an overflow test, then one quotient bit per stage.
// Reset clears all valid bits, the queue and the registers (time step 41, wind 0).
// An output stall freezes the back end; the front end keeps filling the queue
// until it is full, and only then drops in_ready.
`timescale 1ns / 1ps

module triangle_wind_force_top
    import twf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  twf_in_t              in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output twf_out_t             out_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] time_step_reg;
    logic [CFG_W-1:0] wind_x_reg;
    logic [CFG_W-1:0] wind_y_reg;
    logic [CFG_W-1:0] wind_z_reg;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic             back_ready;
    twf_mid_t         push_item;
    twf_mid_t         pop_item;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
            wind_x_reg    <= '0;
            wind_y_reg    <= '0;
            wind_z_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP: time_step_reg <= cfg_data;
                REG_WIND_X:    wind_x_reg    <= cfg_data;
                REG_WIND_Y:    wind_y_reg    <= cfg_data;
                REG_WIND_Z:    wind_z_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    twf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .wind_x    (wind_x_reg),
        .wind_y    (wind_y_reg),
        .wind_z    (wind_z_reg),
        .push      (push),
        .full      (full),
        .push_item (push_item)
    );

    twf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    // A queued triangle transfers into the back end whenever the back end advances.
    assign pop = !empty && back_ready;

    twf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!empty),
        .in_ready  (back_ready),
        .in_item   (pop_item),
        .time_step (time_step_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== sv/twf_mul.sv =====
// Pipelined unsigned multiplier built from limb partial products.
`timescale 1ns / 1ps

module twf_mul
    import twf_pkg::*;
#(
    parameter int AW = 24,
    parameter int BW = 24
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic [AW+BW-1:0] p
);

    localparam int NA    = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB    = (BW + LIMB_W - 1) / LIMB_W;
    localparam int ROW_W = (NB + 1) * LIMB_W;
    localparam int PW    = (NA + NB) * LIMB_W;

    logic [NA*LIMB_W-1:0] a_ext;
    logic [NB*LIMB_W-1:0] b_ext;
    logic [2*LIMB_W-1:0]  pp_reg [NA][NB];
    logic [ROW_W-1:0]     row_sum [NA];
    logic [ROW_W-1:0]     row_reg [NA];
    logic [PW-1:0]        p_sum;
    logic [PW-1:0]        p_reg;

    assign a_ext = (NA*LIMB_W)'(a);
    assign b_ext = (NB*LIMB_W)'(b);

    // Stage one: limb by limb products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_ext[i*LIMB_W +: LIMB_W] * b_ext[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    // Stage two: one row sum for each limb of a.
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_sum[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_sum[i] = row_sum[i] + (ROW_W'(pp_reg[i][j]) << (j * LIMB_W));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_sum;
        end
    end

    // Stage three: rows added into the full product.
    always_comb
    begin
        p_sum = '0;
        for (int i = 0; i < NA; i++)
        begin
            p_sum = p_sum + (PW'(row_reg[i]) << (i * LIMB_W));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_sum;
        end
    end

    assign p = p_reg[AW+BW-1:0];

endmodule

// ===== sv/twf_div.sv =====
// Pipelined restoring divider: one quotient bit per stage plus an overflow test.
`timescale 1ns / 1ps

module twf_div
    import twf_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   q,
    output logic             over
);

    logic [REM_W-1:0] rem_reg  [0:Q_W];
    logic [DEN_W-1:0] den_reg  [0:Q_W-1];
    logic [Q_W-1:0]   q_reg    [0:Q_W];
    logic             over_reg [0:Q_W];

    // First stage flags a quotient that does not fit in the result width.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            over_reg[0] <= REM_W'(num) >= REM_W'({den, {Q_W{1'b0}}});
            rem_reg[0]  <= REM_W'(num);
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
        end
    end

    // Each later stage settles one quotient bit, most significant first.
    for (genvar k = 1; k <= Q_W; k++)
    begin : g_stage
        logic [REM_W:0] trial;

        assign trial = {1'b0, rem_reg[k-1]} - {1'b0, (REM_W'(den_reg[k-1]) << (Q_W - k))};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= trial[REM_W] ? rem_reg[k-1] : trial[REM_W-1:0];
                q_reg[k]    <= q_reg[k-1] | (trial[REM_W] ? '0 : (Q_W'(1) << (Q_W - k)));
                over_reg[k] <= over_reg[k-1];
            end
        end

        if (k < Q_W)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign q    = q_reg[Q_W];
    assign over = over_reg[Q_W];

endmodule

// ===== sv/twf_front.sv =====
// Front end: takes triangles, forms edges, relative velocity sum and normal, flags zero area.
`timescale 1ns / 1ps

module twf_front
    import twf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  twf_in_t          in_item,
    input  logic [CFG_W-1:0] wind_x,
    input  logic [CFG_W-1:0] wind_y,
    input  logic [CFG_W-1:0] wind_z,
    output logic             push,
    input  logic             full,
    output twf_mid_t         push_item
);

    localparam int W = COMPONENT_BITS;

    logic [IN_W-1:0]        pos [3];
    logic [IN_W-1:0]        vel [3];
    logic signed [CFG_W-1:0] wind [3];
    logic signed [E_W-1:0]  e1 [3];
    logic signed [E_W-1:0]  e2 [3];
    logic signed [VS_W-1:0] vs [3];

    logic signed [E_W-1:0]    e1_reg [3];
    logic signed [E_W-1:0]    e2_reg [3];
    logic signed [VS_W-1:0]   vs1_reg [3];
    logic signed [2*E_W-1:0]  pr_reg [6];
    logic signed [VS_W-1:0]   vs2_reg [3];
    logic signed [N_W-1:0]    n [3];
    logic [3:1]               vld_reg;
    logic                     adv;

    // The front advances unless its last stage holds an item the queue cannot take.
    assign adv      = !vld_reg[3] || !full;
    assign in_ready = adv;
    assign push     = vld_reg[3] && !full;

    assign pos  = '{in_item.pos_a, in_item.pos_b, in_item.pos_c};
    assign vel  = '{in_item.vel_a, in_item.vel_b, in_item.vel_c};
    assign wind = '{$signed(wind_x), $signed(wind_y), $signed(wind_z)};

    // Edges and the velocity sum less three times the wind.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            e1[c] = E_W'($signed(pos[1][c*W +: W])) - E_W'($signed(pos[0][c*W +: W]));
            e2[c] = E_W'($signed(pos[2][c*W +: W])) - E_W'($signed(pos[0][c*W +: W]));
            vs[c] = VS_W'($signed(vel[0][c*W +: W])) + VS_W'($signed(vel[1][c*W +: W]))
                  + VS_W'($signed(vel[2][c*W +: W]))
                  - (VS_W'(wind[c]) <<< 1) - VS_W'(wind[c]);
        end
    end

    // Cross product terms, then their differences.
    always_comb
    begin
        n[0] = N_W'(pr_reg[0]) - N_W'(pr_reg[1]);
        n[1] = N_W'(pr_reg[2]) - N_W'(pr_reg[3]);
        n[2] = N_W'(pr_reg[4]) - N_W'(pr_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg    <= e1;
            e2_reg    <= e2;
            vs1_reg   <= vs;
            pr_reg[0] <= e1_reg[1] * e2_reg[2];
            pr_reg[1] <= e1_reg[2] * e2_reg[1];
            pr_reg[2] <= e1_reg[2] * e2_reg[0];
            pr_reg[3] <= e1_reg[0] * e2_reg[2];
            pr_reg[4] <= e1_reg[0] * e2_reg[1];
            pr_reg[5] <= e1_reg[1] * e2_reg[0];
            vs2_reg   <= vs1_reg;
            for (int c = 0; c < 3; c++)
            begin
                push_item.n[c]  <= n[c];
                push_item.vs[c] <= vs2_reg[c];
            end
            push_item.deg <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:1], in_valid};
        end
    end

endmodule

// ===== sv/twf_queue.sv =====
// Short first-in first-out queue between the front end and the back end.
`timescale 1ns / 1ps

module twf_queue
    import twf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  twf_mid_t push_item,
    output logic     full,
    input  logic     pop,
    output twf_mid_t pop_item,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    twf_mid_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = mem_reg[rd_ptr_reg];

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/twf_back.sv =====
// Back end: dot product, drag scaling, division by nine times squared normal, saturation.
`timescale 1ns / 1ps

module twf_back
    import twf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  twf_mid_t         in_item,
    input  logic [CFG_W-1:0] time_step,
    output logic             out_valid,
    input  logic             out_ready,
    output twf_out_t         out_item
);

    // Stage numbers of the pipeline, counted from the register after the queue.
    localparam int P_SQ  = 1 + MUL_LAT;
    localparam int P_SUM = P_SQ + 1;
    localparam int P_ABS = P_SUM + 1;
    localparam int P_DSQ = P_ABS + MUL_LAT;
    localparam int P_NUM = P_DSQ + MUL_LAT;
    localparam int P_DIV = P_NUM + DIV_LAT;
    localparam int P_OUT = P_DIV + 1;

    typedef struct packed {
        logic                 deg;
        logic [2:0]           nsign;
        logic [2:0]           tsign;
        logic [2:0][NM_W-1:0] nmag;
    } twf_side_a_t;

    typedef struct packed {
        logic       deg;
        logic [2:0] neg;
    } twf_side_b_t;

    logic                 adv;
    logic [P_OUT:1]       vld_reg;
    twf_side_a_t          sa_in;
    twf_side_a_t          sa_d [1:P_ABS];
    twf_side_b_t          sb_in;
    twf_side_b_t          sb_d [P_ABS+1:P_DIV];
    logic [VM_W-1:0]      vmag_reg [3];
    logic [VM_W-1:0]      vmag [3];
    logic [G_W-1:0]       g_reg;
    logic [2*NM_W-1:0]    sq [3];
    logic [NM_W+VM_W-1:0] pv [3];
    logic [NN_W-1:0]      nn_sum;
    logic signed [D_W:0]  dsum;
    logic [NN_W-1:0]      nn_reg;
    logic signed [D_W:0]  dsum_reg;
    logic                 dsign_reg;
    logic [D_W-1:0]       dmag_reg;
    logic [DEN_W-1:0]     den_d [P_ABS:P_NUM];
    logic [DSQ_W-1:0]     dsq;
    logic [M_W-1:0]       mc [3];
    logic [PROD_W-1:0]    prod [3];
    logic [Q_W-1:0]       q [3];
    logic                 q_over [3];
    twf_out_t             out_next;

    // All stages move together; the output register frees the pipeline when taken.
    assign adv       = !vld_reg[P_OUT] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[P_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[P_OUT-1:1], in_valid};
        end
    end

    // Drag gain times step length; the user changes configuration only while idle, the block does not enforce it.
    always_ff @(posedge clk)
    begin
        g_reg <= G_W'(DRAG_GAIN) * G_W'(time_step);
    end

    // Sign and magnitude split of the normal and of the velocity sum.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic signed [N_W-1:0]  ns;
            logic signed [VS_W-1:0] vv;
            ns = $signed(in_item.n[c]);
            vv = $signed(in_item.vs[c]);
            sa_in.nsign[c] = ns[N_W-1];
            sa_in.nmag[c]  = NM_W'(ns[N_W-1] ? -ns : ns);
            sa_in.tsign[c] = ns[N_W-1] ^ vv[VS_W-1];
            vmag[c]        = VM_W'(vv[VS_W-1] ? -vv : vv);
        end
        sa_in.deg = in_item.deg;
    end

    // Squared normal length and the signed dot product.
    always_comb
    begin
        nn_sum = '0;
        dsum   = '0;
        for (int c = 0; c < 3; c++)
        begin
            logic signed [D_W:0] term;
            term   = $signed((D_W+1)'(pv[c]));
            nn_sum = nn_sum + NN_W'(sq[c]);
            dsum   = sa_d[P_SQ].tsign[c] ? dsum - term : dsum + term;
        end
    end

    // The result is negative where the dot product and the normal component agree in sign.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sb_in.neg[c] = dsign_reg == sa_d[P_ABS].nsign[c];
        end
        sb_in.deg = sa_d[P_ABS].deg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_d[1]  <= sa_in;
            vmag_reg <= vmag;
            for (int k = 2; k <= P_ABS; k++)
            begin
                sa_d[k] <= sa_d[k-1];
            end
            nn_reg    <= nn_sum;
            dsum_reg  <= dsum;
            dsign_reg <= dsum_reg[D_W];
            dmag_reg  <= D_W'(dsum_reg[D_W] ? -dsum_reg : dsum_reg);
            den_d[P_ABS] <= (DEN_W'(nn_reg) << 3) + DEN_W'(nn_reg);
            for (int k = P_ABS + 1; k <= P_NUM; k++)
            begin
                den_d[k] <= den_d[k-1];
            end
            sb_d[P_ABS+1] <= sb_in;
            for (int k = P_ABS + 2; k <= P_DIV; k++)
            begin
                sb_d[k] <= sb_d[k-1];
            end
            out_item <= out_next;
        end
    end

    twf_mul #(.AW(D_W), .BW(D_W)) u_dsq (
        .clk (clk),
        .en  (adv),
        .a   (dmag_reg),
        .b   (dmag_reg),
        .p   (dsq)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        twf_mul #(.AW(NM_W), .BW(NM_W)) u_sq (
            .clk (clk),
            .en  (adv),
            .a   (sa_d[1].nmag[c]),
            .b   (sa_d[1].nmag[c]),
            .p   (sq[c])
        );

        twf_mul #(.AW(NM_W), .BW(VM_W)) u_pv (
            .clk (clk),
            .en  (adv),
            .a   (sa_d[1].nmag[c]),
            .b   (vmag_reg[c]),
            .p   (pv[c])
        );

        twf_mul #(.AW(G_W), .BW(NM_W)) u_mc (
            .clk (clk),
            .en  (adv),
            .a   (g_reg),
            .b   (sa_d[P_ABS].nmag[c]),
            .p   (mc[c])
        );

        twf_mul #(.AW(DSQ_W), .BW(M_W)) u_num (
            .clk (clk),
            .en  (adv),
            .a   (dsq),
            .b   (mc[c]),
            .p   (prod[c])
        );

        twf_div u_div (
            .clk  (clk),
            .en   (adv),
            .num  (prod[c][PROD_W-1:DEN_SHIFT]),
            .den  (den_d[P_NUM]),
            .q    (q[c]),
            .over (q_over[c])
        );
    end

    // Sign, saturation and the zero area override.
    always_comb
    begin
        logic [Q_W-1:0] val [3];
        logic           sat;
        sat = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            logic [Q_W-1:0] limit;
            logic           clip;
            limit = sb_d[P_DIV].neg[c] ? NEG_LIMIT : POS_LIMIT;
            clip  = q_over[c] || (q[c] > limit);
            sat   = sat | clip;
            if (clip)
            begin
                val[c] = limit;
            end
            else
            begin
                val[c] = sb_d[P_DIV].neg[c] ? -q[c] : q[c];
            end
        end
        if (sb_d[P_DIV].deg)
        begin
            out_next.delta_vx   = '0;
            out_next.delta_vy   = '0;
            out_next.delta_vz   = '0;
            out_next.degenerate = 1'b1;
            out_next.saturated  = 1'b0;
        end
        else
        begin
            out_next.delta_vx   = $signed(val[0]);
            out_next.delta_vy   = $signed(val[1]);
            out_next.delta_vz   = $signed(val[2]);
            out_next.degenerate = 1'b0;
            out_next.saturated  = sat;
        end
    end

endmodule

// ===== sv/twf_checker.sv =====
// Port-level checks for the triangle wind force block, bound to its top level.
`timescale 1ns / 1ps

module twf_checker
    import twf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input twf_out_t out_item
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item)
    ) else $error("stalled result changed");

    // A zero-area triangle delivers zero increments and no clip flag.
    a_degenerate_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_item.degenerate |->
            out_item.delta_vx == '0 && out_item.delta_vy == '0 &&
            out_item.delta_vz == '0 && !out_item.saturated
    ) else $error("degenerate result not zero");

    // A clip flag means at least one component sits at a limit.
    a_saturated_limit: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_item.saturated |->
            out_item.delta_vx == $signed(POS_LIMIT) || out_item.delta_vx == $signed(NEG_LIMIT) ||
            out_item.delta_vy == $signed(POS_LIMIT) || out_item.delta_vy == $signed(NEG_LIMIT) ||
            out_item.delta_vz == $signed(POS_LIMIT) || out_item.delta_vz == $signed(NEG_LIMIT)
    ) else $error("saturated flag without a clipped component");

endmodule

bind triangle_wind_force_top twf_checker u_twf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ===== bench/triangle_wind_force_top_tb.sv =====
// Self-checking testbench for the triangle wind force block.
`timescale 1ns / 1ps

module triangle_wind_force_top_tb;
    import twf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    twf_in_t              in_item;
    logic                 out_valid;
    logic                 out_ready;
    twf_out_t             out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0] dt_reg;
    logic [CFG_W-1:0] wind_reg [3];

    twf_out_t pending_deltas[$];
    int       mismatches;
    int       idle_cycles;
    bit       tx_calm;
    bit       rx_calm;
    bit       hold_req;
    int       hold_cnt;

    triangle_wind_force_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Expected drag increment: -165 * dt * d * |d| * n / (9 * |n|^2 * 2^52), done exactly in wide integers.
    function automatic twf_out_t drag_increment(twf_in_t it);
        logic [IN_W-1:0]    fld [6];
        logic signed [63:0] p [3][3];
        logic signed [63:0] vsum [3];
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] nv [3];
        logic [255:0]       nn, dpos, dneg, dmag, base, den, q, an, av;
        logic               dsign, negc;
        logic [31:0]        limit;
        twf_out_t           r;
        fld = '{it.pos_a, it.pos_b, it.pos_c, it.vel_a, it.vel_b, it.vel_c};
        for (int c = 0; c < 3; c++)
        begin
            vsum[c] = -3 * longint'($signed(wind_reg[c]));
            for (int k = 0; k < 3; k++)
            begin
                p[k][c] = longint'($signed(fld[k][c*COMPONENT_BITS +: COMPONENT_BITS]));
                vsum[c] += longint'($signed(fld[3+k][c*COMPONENT_BITS +: COMPONENT_BITS]));
            end
            e1[c] = p[1][c] - p[0][c];
            e2[c] = p[2][c] - p[0][c];
        end
        nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nv[2] = e1[0] * e2[1] - e1[1] * e2[0];

        nn   = '0;
        dpos = '0;
        dneg = '0;
        for (int c = 0; c < 3; c++)
        begin
            an = 256'(nv[c] < 0 ? -nv[c] : nv[c]);
            av = 256'(vsum[c] < 0 ? -vsum[c] : vsum[c]);
            nn += an * an;
            if ((nv[c] < 0) != (vsum[c] < 0))
                dneg += an * av;
            else
                dpos += an * av;
        end

        r = '0;
        if (nn == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end

        dsign = dneg > dpos;
        dmag  = dsign ? dneg - dpos : dpos - dneg;
        base  = 256'(DRAG_GAIN) * 256'(dt_reg) * dmag * dmag;
        den   = (nn * 256'(9)) << DEN_SHIFT;
        for (int c = 0; c < 3; c++)
        begin
            negc  = (dsign == (nv[c] < 0));
            limit = negc ? NEG_LIMIT : POS_LIMIT;
            an    = 256'(nv[c] < 0 ? -nv[c] : nv[c]);
            q     = (base * an) / den;
            if (q[255:32] != 0 || q[31:0] > limit)
            begin
                r.saturated = 1'b1;
                q[31:0]     = limit;
            end
            else if (negc)
            begin
                q[31:0] = -q[31:0];
            end
            case (c)
                0: r.delta_vx = q[31:0];
                1: r.delta_vy = q[31:0];
                default: r.delta_vz = q[31:0];
            endcase
        end
        return r;
    endfunction

    // One register write, mirrored into the shadow copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TIME_STEP: dt_reg      = val;
            REG_WIND_X:    wind_reg[0] = val;
            REG_WIND_Y:    wind_reg[1] = val;
            REG_WIND_Z:    wind_reg[2] = val;
            default: ;
        endcase
    endtask

    // Offer one triangle, wait for its transfer, then maybe leave a gap.
    task automatic send_triangle(twf_in_t it);
        int gap;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_deltas.push_back(drag_increment(it));
        if (!tx_calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets the pipeline empty out before the configuration changes.
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_deltas.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COMPONENT_BITS-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return COMPONENT_BITS'($urandom);
            1: return {1'b0, {(COMPONENT_BITS-1){1'b1}}};
            2: return {1'b1, {(COMPONENT_BITS-1){1'b0}}};
            default: return COMPONENT_BITS'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_vec();
        return {rand_comp(), rand_comp(), rand_comp()};
    endfunction

    // A triangle either fully random or a small one around a random center.
    function automatic twf_in_t rand_triangle();
        twf_in_t          t;
        logic [IN_W-1:0]  ctr;
        t = {rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec()};
        if ($urandom_range(0, 2) != 0)
        begin
            ctr = {3{COMPONENT_BITS'($urandom_range(0, 65535) - 32768)}};
            for (int c = 0; c < 3; c++)
            begin
                t.pos_b[c*COMPONENT_BITS +: COMPONENT_BITS] = ctr[c*COMPONENT_BITS +: COMPONENT_BITS]
                    + COMPONENT_BITS'($urandom_range(0, 16384) - 8192);
                t.pos_c[c*COMPONENT_BITS +: COMPONENT_BITS] = ctr[c*COMPONENT_BITS +: COMPONENT_BITS]
                    + COMPONENT_BITS'($urandom_range(0, 16384) - 8192);
                t.pos_a[c*COMPONENT_BITS +: COMPONENT_BITS] = ctr[c*COMPONENT_BITS +: COMPONENT_BITS];
            end
        end
        return t;
    endfunction

    function automatic logic [CFG_W-1:0] rand_cfg();
        case ($urandom_range(0, 3))
            0: return {CFG_W{1'b1}};
            1: return {1'b1, {(CFG_W-1){1'b0}}};
            2: return {1'b0, {(CFG_W-1){1'b1}}};
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // Zero area, collinear, extreme and saturating triangles under reset settings.
    task automatic test_directed();
        twf_in_t t;
        logic [IN_W-1:0] vmax, vmin, unit;
        vmax = {3{1'b0, {(COMPONENT_BITS-1){1'b1}}}};
        vmin = {3{1'b1, {(COMPONENT_BITS-1){1'b0}}}};
        unit = {20'h0, 20'h0, 20'h01000};
        send_triangle('0);
        send_triangle('1);
        send_triangle({vmax, vmax, vmax, vmax, vmax, vmax});
        send_triangle({vmin, vmin, vmin, vmin, vmin, vmin});
        // Collinear points give a zero normal.
        send_triangle({{20'h0, 20'h0, 20'h03000}, {20'h0, 20'h0, 20'h02000},
                       {20'h0, 20'h0, 20'h01000}, vmax, vmin, vmax});
        // Unit triangle in the xy plane, velocity along z, both signs.
        t = '0;
        t.pos_b = {20'h0, 20'h0, 20'h01000};
        t.pos_c = {20'h0, 20'h01000, 20'h0};
        t.vel_a = {20'h01000, 20'h0, 20'h0};
        send_triangle(t);
        t.vel_a = {20'hFF000, 20'h0, 20'h0};
        send_triangle(t);
        // Huge triangle with extreme velocities saturates.
        t.pos_a = vmin;
        t.pos_b = {vmin[59:20], vmax[19:0]};
        t.pos_c = {vmin[59:40], vmax[39:20], vmin[19:0]};
        t.vel_a = vmax;
        t.vel_b = vmax;
        t.vel_c = vmax;
        send_triangle(t);
        t.vel_a = vmin;
        t.vel_b = vmin;
        t.vel_c = vmin;
        send_triangle(t);
        t.vel_b = unit;
        send_triangle(t);
        for (int i = 0; i < 8; i++)
            send_triangle({rand_vec(), rand_vec(), rand_vec(), vmax, vmin, rand_vec()});
        drain();
    endtask

    // Every register through its extremes, plus unknown indexes that must be ignored.
    task automatic test_config_extremes();
        write_reg(REG_TIME_STEP, '0);
        write_reg(REG_WIND_X, {1'b1, {(CFG_W-1){1'b0}}});
        write_reg(REG_WIND_Y, {1'b0, {(CFG_W-1){1'b1}}});
        write_reg(REG_WIND_Z, '1);
        write_reg(CFG_IDX_W'(7), '1);
        for (int i = 0; i < 20; i++)
            send_triangle(rand_triangle());
        drain();
        write_reg(REG_TIME_STEP, '1);
        write_reg(REG_WIND_X, {1'b0, {(CFG_W-1){1'b1}}});
        write_reg(REG_WIND_Y, {1'b1, {(CFG_W-1){1'b0}}});
        write_reg(REG_WIND_Z, CFG_W'(4096));
        write_reg(CFG_IDX_W'(255), '0);
        for (int i = 0; i < 20; i++)
            send_triangle(rand_triangle());
        drain();
    endtask

    // Random triangles over several random settings.
    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            write_reg(REG_TIME_STEP, ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1, 4096))
                                                                  : rand_cfg());
            write_reg(REG_WIND_X, rand_cfg());
            write_reg(REG_WIND_Y, rand_cfg());
            write_reg(REG_WIND_Z, rand_cfg());
            for (int i = 0; i < per_phase; i++)
                send_triangle(rand_triangle());
            drain();
        end
    endtask

    // Receiver stops for a long stretch while triangles keep coming.
    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 150; i++)
            send_triangle(rand_triangle());
        drain();
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_full_rate();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        test_random(2, 100);
    endtask

    // Receiver: random stall bursts, and the long hold when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
        end
        else if (hold_req)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= HOLD_CYCLES;
        end
        else if (hold_cnt > 0)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (!rx_calm && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= $urandom_range(0, 18);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_deltas.size() == 0)
            begin
                if (mismatches < 10)
                    $display("Unexpected result %h", out_item);
                mismatches++;
            end
            else if (out_item !== pending_deltas[0])
            begin
                if (mismatches < 10)
                    $display({"Mismatch: expected dx=%0d dy=%0d dz=%0d deg=%b sat=%b, ",
                              "got dx=%0d dy=%0d dz=%0d deg=%b sat=%b"},
                             pending_deltas[0].delta_vx, pending_deltas[0].delta_vy,
                             pending_deltas[0].delta_vz, pending_deltas[0].degenerate,
                             pending_deltas[0].saturated, out_item.delta_vx, out_item.delta_vy,
                             out_item.delta_vz, out_item.degenerate, out_item.saturated);
                mismatches++;
                void'(pending_deltas.pop_front());
            end
            else
            begin
                void'(pending_deltas.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        dt_reg      = TIME_STEP_RESET;
        wind_reg    = '{default: '0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random(10, 120);
        test_backpressure();
        test_full_rate();

        if (mismatches == 0 && pending_deltas.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/twf_pkg.sv
sv/twf_mul.sv
sv/twf_div.sv
sv/twf_front.sv
sv/twf_queue.sv
sv/twf_back.sv
sv/triangle_wind_force_top.sv
sv/twf_checker.sv
bench/triangle_wind_force_top_tb.sv
